FILE: hdl/rcr_pkg.sv
// rcr_pkg: shared types and constants of the range capacity reservation core
// no dependencies
package rcr_pkg;

  localparam int unsigned SlotLimitDef = 1024;
  localparam int unsigned CapW   = 30;
  localparam int unsigned CountW = 11;
  localparam int unsigned StartW = 10;

  localparam logic [CapW-1:0] CapOnes = {CapW{1'b1}};

  // configuration register indexes
  localparam logic CfgSlotCount = 1'b0;
  localparam logic CfgInitCap   = 1'b1;

  // operation codes
  localparam logic OpRebuild = 1'b0;
  localparam logic OpReserve = 1'b1;

  typedef enum logic [4:0] {
    StFill = 5'b00001,
    StIdle = 5'b00010,
    StScan = 5'b00100,
    StUpd  = 5'b01000,
    StFin  = 5'b10000
  } state_e;

endpackage

FILE: hdl/rcr_ram.sv
// rcr_ram: generic single-clock ram, one write port, one registered read port
// no dependencies
module rcr_ram #(
  parameter int unsigned Width = 30,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/range_capacity_reservation_core.sv
// range_capacity_reservation_core: admission control over a row of slot capacities
// depends on rcr_pkg and rcr_ram
//
//  channel | signals                                         | moves
//  in      | in_valid_i/in_ready_o, operation, slots, demand | one request
//  out     | out_valid_o/out_ready_i, accepted, min_free      | one result per request
//  cfg     | cfg_we_i, cfg_index_i, cfg_data_i                | register write
//
// a reserve request over a non-empty range uses one slot memory port: one read per cycle
// for the minimum scan, then, if granted, one read-modify-write pass
// a rebuild writes every slot, one memory write per cycle
// after reset a clearing pass over all slots runs before in_ready_o rises
// a waiting result holds the next request in its final state until out_ready_i
module range_capacity_reservation_core #(
  parameter int unsigned SLOT_LIMIT = rcr_pkg::SlotLimitDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        operation_i,
  input  logic [rcr_pkg::StartW-1:0]  start_slot_i,
  input  logic [rcr_pkg::CountW-1:0]  end_slot_i,
  input  logic [rcr_pkg::CapW-1:0]    demand_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        accepted_o,
  output logic [rcr_pkg::CapW-1:0]    min_free_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [rcr_pkg::CapW-1:0]    cfg_data_i
);

  localparam int unsigned AW  = $clog2(SLOT_LIMIT);
  localparam int unsigned CW0 = $clog2(SLOT_LIMIT + 1);
  localparam int unsigned CW  = (CW0 > rcr_pkg::CountW) ? CW0 : rcr_pkg::CountW;
  localparam logic [CW-1:0] LimitC = CW'(SLOT_LIMIT);
  localparam logic [CW-1:0] LastC  = CW'(SLOT_LIMIT - 1);

  rcr_pkg::state_e state_q, state_d;

  logic [rcr_pkg::CountW-1:0] slot_count_q;
  logic [rcr_pkg::CapW-1:0]   init_cap_q;
  logic [rcr_pkg::CapW-1:0]   fill_q, fill_d;
  logic [CW-1:0]              cnt_q, cnt_d, hi_q, hi_d;
  logic [CW-1:0]              lo_q, lo_d;
  logic [rcr_pkg::CapW-1:0]   demand_q, demand_d;
  logic [rcr_pkg::CapW-1:0]   min_q, min_d;
  logic                       acc_q, acc_d;
  logic                       rvld_q, rvld_d;
  logic [AW-1:0]              waddr_q, waddr_d;
  logic                       ovalid_q, ovalid_d;
  logic                       item_q, item_d;
  logic                       res_acc_q, res_acc_d;
  logic [rcr_pkg::CapW-1:0]   res_min_q, res_min_d;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [rcr_pkg::CapW-1:0]   wdata, rdata;
  logic [CW-1:0]              n_use, end_ext, end_clip, start_ext;
  logic                       issue;

  // slot capacity memory
  rcr_ram #(.Width(rcr_pkg::CapW), .Depth(SLOT_LIMIT)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // range clipping
  always_comb begin
    n_use     = (CW'(slot_count_q) > LimitC) ? LimitC : CW'(slot_count_q);
    end_ext   = CW'(end_slot_i);
    start_ext = CW'(start_slot_i);
    end_clip  = (end_ext > n_use) ? n_use : end_ext;
  end

  assign in_ready_o  = (state_q == rcr_pkg::StIdle);
  assign out_valid_o = ovalid_q;
  assign accepted_o  = res_acc_q;
  assign min_free_o  = res_min_q;
  assign issue       = (cnt_q != hi_q);

  // sequencer
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    cnt_d     = cnt_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    demand_d  = demand_q;
    min_d     = min_q;
    acc_d     = acc_q;
    rvld_d    = 1'b0;
    waddr_d   = waddr_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    item_d    = item_q;
    res_acc_d = res_acc_q;
    res_min_d = res_min_q;
    we        = 1'b0;
    waddr     = cnt_q[AW-1:0];
    wdata     = fill_q;
    case (state_q)
      rcr_pkg::StFill: begin
        we    = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastC) begin
          acc_d   = 1'b1;
          min_d   = '0;
          state_d = item_q ? rcr_pkg::StFin : rcr_pkg::StIdle;
        end
      end
      rcr_pkg::StIdle: begin
        if (in_valid_i) begin
          item_d   = 1'b1;
          demand_d = demand_i;
          if (operation_i == rcr_pkg::OpRebuild) begin
            fill_d  = init_cap_q;
            cnt_d   = '0;
            state_d = rcr_pkg::StFill;
          end else if (start_ext >= end_clip) begin
            acc_d   = 1'b1;
            min_d   = rcr_pkg::CapOnes;
            state_d = rcr_pkg::StFin;
          end else begin
            cnt_d   = start_ext;
            lo_d    = start_ext;
            hi_d    = end_clip;
            min_d   = rcr_pkg::CapOnes;
            state_d = rcr_pkg::StScan;
          end
        end
      end
      rcr_pkg::StScan: begin
        // one read per cycle, minimum folded in the cycle after the read
        if (issue) begin
          cnt_d  = cnt_q + 1'b1;
          rvld_d = 1'b1;
        end
        if (rvld_q && rdata < min_q) begin
          min_d = rdata;
        end
        if (!issue && !rvld_q) begin
          if (min_q >= demand_q) begin
            cnt_d   = lo_q;
            state_d = rcr_pkg::StUpd;
          end else begin
            acc_d   = 1'b0;
            state_d = rcr_pkg::StFin;
          end
        end
      end
      rcr_pkg::StUpd: begin
        // read ahead, write back the previous slot lowered by the demand
        if (issue) begin
          cnt_d   = cnt_q + 1'b1;
          rvld_d  = 1'b1;
          waddr_d = cnt_q[AW-1:0];
        end
        if (rvld_q) begin
          we    = 1'b1;
          waddr = waddr_q;
          wdata = rdata - demand_q;
        end
        if (!issue && !rvld_q) begin
          acc_d   = 1'b1;
          state_d = rcr_pkg::StFin;
        end
      end
      rcr_pkg::StFin: begin
        // hand the result to the output register once it is free
        if (!ovalid_q || out_ready_i) begin
          ovalid_d  = 1'b1;
          res_acc_d = acc_q;
          res_min_d = min_q;
          item_d    = 1'b0;
          state_d   = rcr_pkg::StIdle;
        end
      end
      default: state_d = rcr_pkg::StIdle;
    endcase
  end

  // control and payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rcr_pkg::StFill;
      fill_q       <= '0;
      cnt_q        <= '0;
      hi_q         <= '0;
      rvld_q       <= 1'b0;
      ovalid_q     <= 1'b0;
      item_q       <= 1'b0;
      res_acc_q    <= 1'b0;
      res_min_q    <= '0;
      slot_count_q <= rcr_pkg::CountW'(1024);
      init_cap_q   <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      cnt_q     <= cnt_d;
      hi_q      <= hi_d;
      rvld_q    <= rvld_d;
      ovalid_q  <= ovalid_d;
      item_q    <= item_d;
      res_acc_q <= res_acc_d;
      res_min_q <= res_min_d;
      if (cfg_we_i && cfg_index_i == rcr_pkg::CfgSlotCount) begin
        slot_count_q <= cfg_data_i[rcr_pkg::CountW-1:0];
      end
      if (cfg_we_i && cfg_index_i == rcr_pkg::CfgInitCap) begin
        init_cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    demand_q <= demand_d;
    min_q    <= min_d;
    acc_q    <= acc_d;
    waddr_q  <= waddr_d;
  end

endmodule

FILE: hdl/rcr_checker.sv
// rcr_checker: port-level checks of the range capacity reservation core
// depends on rcr_pkg; bound to range_capacity_reservation_core
module rcr_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic                     accepted_o,
  input logic [rcr_pkg::CapW-1:0] min_free_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(min_free_o) && $stable(accepted_o))
    else $error("stalled result changed");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // a rejection always has a real minimum below the sentinel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !accepted_o |-> min_free_o != rcr_pkg::CapOnes)
    else $error("rejected empty range");

  // no result right after reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result after reset");

endmodule

bind range_capacity_reservation_core rcr_checker u_rcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .accepted_o  (accepted_o),
  .min_free_o  (min_free_o)
);

FILE: tb/tb_range_capacity_reservation_core.sv
// tb_range_capacity_reservation_core: self-checking regression of the reservation core
// depends on rcr_pkg and range_capacity_reservation_core; flat slot array predictor
`timescale 1ns / 100ps

module tb_range_capacity_reservation_core;

  localparam int unsigned Slots     = rcr_pkg::SlotLimitDef;
  localparam int unsigned StallMax  = 40000;
  localparam int unsigned RandItems = 1650;

  typedef struct packed {
    logic                     accepted;
    logic [rcr_pkg::CapW-1:0] min_free;
  } grant_t;

  // slot capacity model and queue of pending grants
  class reservation_board;
    logic [rcr_pkg::CapW-1:0]   slot_cap [Slots];
    logic [rcr_pkg::CountW-1:0] slot_count;
    logic [rcr_pkg::CapW-1:0]   init_cap;
    grant_t                     grant_q [$];
    int unsigned                errors, rebuilds, granted, refused, empties;

    function new();
      foreach (slot_cap[i]) slot_cap[i] = '0;
      slot_count = rcr_pkg::CountW'(Slots);
      init_cap   = '0;
      errors = 0; rebuilds = 0; granted = 0; refused = 0; empties = 0;
    endfunction

    function void write_reg(logic idx, logic [rcr_pkg::CapW-1:0] data);
      if (idx == rcr_pkg::CfgSlotCount) slot_count = data[rcr_pkg::CountW-1:0];
      else init_cap = data;
    endfunction

    // predict the grant of one accepted request
    function void note_request(logic op, logic [rcr_pkg::StartW-1:0] first,
                               logic [rcr_pkg::CountW-1:0] stop,
                               logic [rcr_pkg::CapW-1:0] demand);
      grant_t      g;
      int unsigned n, hi, lowest;
      if (op == rcr_pkg::OpRebuild) begin
        foreach (slot_cap[i]) slot_cap[i] = init_cap;
        g.accepted = 1'b1;
        g.min_free = '0;
        rebuilds++;
      end else begin
        n  = (slot_count > Slots) ? Slots : slot_count;
        hi = (stop > n) ? n : stop;
        if (first >= hi) begin
          g.accepted = 1'b1;
          g.min_free = rcr_pkg::CapOnes;
          empties++;
        end else begin
          lowest = rcr_pkg::CapOnes;
          for (int unsigned i = first; i < hi; i++)
            if (slot_cap[i] < lowest) lowest = slot_cap[i];
          g.min_free = rcr_pkg::CapW'(lowest);
          g.accepted = (lowest >= demand);
          if (g.accepted) begin
            for (int unsigned i = first; i < hi; i++) slot_cap[i] = slot_cap[i] - demand;
            granted++;
          end else begin
            refused++;
          end
        end
      end
      grant_q.push_back(g);
    endfunction

    function void check_result(logic acc, logic [rcr_pkg::CapW-1:0] mf);
      grant_t g;
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected result accepted=%0d min_free=%0h", $time, acc, mf);
        errors++;
        return;
      end
      g = grant_q.pop_front();
      if (acc !== g.accepted) begin
        $display("%0t: accepted expected %0d actual %0d", $time, g.accepted, acc);
        errors++;
      end
      if (mf !== g.min_free) begin
        $display("%0t: min_free expected %0h actual %0h", $time, g.min_free, mf);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic                       operation_i = rcr_pkg::OpReserve;
  logic [rcr_pkg::StartW-1:0] start_slot_i = '0;
  logic [rcr_pkg::CountW-1:0] end_slot_i = '0;
  logic [rcr_pkg::CapW-1:0]   demand_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic                       accepted_o;
  logic [rcr_pkg::CapW-1:0]   min_free_o;
  logic                       cfg_we_i = 1'b0;
  logic                       cfg_index_i = rcr_pkg::CfgSlotCount;
  logic [rcr_pkg::CapW-1:0]   cfg_data_i = '0;

  reservation_board board = new();
  bit               quiet = 1'b0;
  int unsigned      stall_cnt = 0;

  range_capacity_reservation_core dut (.*);

  always #5 clk_i = ~clk_i;

  // result side: random backpressure, check on handshake
  always @(negedge clk_i)
    if (rst_ni) out_ready_i <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 38);

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(accepted_o, min_free_o);

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= StallMax) begin
      $display("range_capacity_reservation_core regression: fail");
      $finish;
    end
  end

  task automatic send_req(logic op, int unsigned first, int unsigned stop,
                          logic [rcr_pkg::CapW-1:0] demand);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 99) < 38) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    start_slot_i <= rcr_pkg::StartW'(first);
    end_slot_i   <= rcr_pkg::CountW'(stop);
    demand_i     <= demand;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(op, rcr_pkg::StartW'(first), rcr_pkg::CountW'(stop), demand);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.grant_q.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [rcr_pkg::CapW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    board.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one random reserve or an occasional rebuild
  task automatic random_req();
    int unsigned first, stop, pick;
    logic [rcr_pkg::CapW-1:0] demand;
    pick  = $urandom_range(0, 99);
    first = $urandom_range(0, Slots - 1);
    if (pick < 3) begin
      send_req(rcr_pkg::OpRebuild, first, $urandom_range(0, Slots),
               rcr_pkg::CapW'($urandom()));
      return;
    end
    if (pick < 6) begin
      first = $urandom_range(0, 3);
      stop  = Slots - $urandom_range(0, 1);
    end else if (pick < 12) begin
      stop = $urandom_range(0, Slots);
    end else begin
      stop = first + $urandom_range(0, 40);
      if (stop > Slots) stop = Slots;
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) demand = rcr_pkg::CapW'($urandom_range(0, (board.init_cap >> 6) + 1));
    else if (pick < 9) demand = rcr_pkg::CapW'($urandom());
    else demand = '0;
    send_req(rcr_pkg::OpReserve, first, stop, demand);
  endtask

  initial begin
    int unsigned counts [5];
    logic [rcr_pkg::CapW-1:0] caps [5];
    counts = '{1024, 1, 0, 2047, 37};
    caps   = '{rcr_pkg::CapOnes, rcr_pkg::CapW'(1000000000), rcr_pkg::CapW'(12345),
               rcr_pkg::CapW'(1000), rcr_pkg::CapW'(0)};

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: state straight after reset, all slots empty
    send_req(rcr_pkg::OpReserve, 0, 1024, '0);
    send_req(rcr_pkg::OpReserve, 5, 9, rcr_pkg::CapW'(1));
    drain();
    write_reg(rcr_pkg::CfgSlotCount, rcr_pkg::CapW'(1024));
    write_reg(rcr_pkg::CfgInitCap, rcr_pkg::CapOnes);
    send_req(rcr_pkg::OpRebuild, 1023, 1024, rcr_pkg::CapOnes);
    send_req(rcr_pkg::OpReserve, 0, 1024, rcr_pkg::CapOnes);
    send_req(rcr_pkg::OpReserve, 0, 1024, rcr_pkg::CapW'(1));
    send_req(rcr_pkg::OpReserve, 1023, 1024, '0);
    send_req(rcr_pkg::OpReserve, 600, 600, rcr_pkg::CapW'(3));
    send_req(rcr_pkg::OpReserve, 700, 10, rcr_pkg::CapW'(3));
    send_req(rcr_pkg::OpReserve, 0, 1, rcr_pkg::CapW'(1000000000));
    send_req(rcr_pkg::OpReserve, 0, 2, rcr_pkg::CapOnes);
    send_req(rcr_pkg::OpReserve, 512, 513, '0);
    drain();
    write_reg(rcr_pkg::CfgSlotCount, rcr_pkg::CapW'(300));
    send_req(rcr_pkg::OpReserve, 250, 1024, rcr_pkg::CapW'(7));
    send_req(rcr_pkg::OpReserve, 300, 1024, rcr_pkg::CapW'(7));
    send_req(rcr_pkg::OpReserve, 299, 300, rcr_pkg::CapW'(1000000000));
    drain();

    // random phases across register settings
    for (int p = 0; p < 5; p++) begin
      drain();
      write_reg(rcr_pkg::CfgSlotCount, rcr_pkg::CapW'(counts[p]));
      write_reg(rcr_pkg::CfgInitCap, caps[p]);
      send_req(rcr_pkg::OpRebuild, 0, 0, '0);
      for (int k = 0; k < RandItems / 5; k++) begin
        quiet = (p == 1) && (k >= 60) && (k < 160);
        if (p == 2 && k == 100) begin
          drain();
        end
        random_req();
      end
      quiet = 1'b0;
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d rebuilds, %0d granted, %0d refused, %0d empty-range reserves",
             board.rebuilds, board.granted, board.refused, board.empties);
    $display("over five slot_count / initial_capacity settings with random backpressure");
    if (board.errors == 0 && board.grant_q.size() == 0) begin
      $display("range_capacity_reservation_core regression: pass");
    end else begin
      $display("range_capacity_reservation_core regression: fail");
    end
    $finish;
  end

endmodule
